### hdl/pdvd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdvd_pkg: shared types and constants of the postings decoder
// Holds the header and varint limits and the job that the front part passes
// through the queue to the back part.
// ----------------------------------------------------------------------------
package pdvd_pkg;

	localparam int HEADER_LEN       = 4;
	localparam int MAX_VARINT_BYTES = 10;
	localparam int QUEUE_DEPTH      = 2;
	localparam int QUEUE_PTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [63:0] delta;
		logic        first;
		logic        last;
		logic        empty;
		logic        ovf;
	} job_t;

	typedef struct packed {
		logic push;
		logic pop;
	} queue_ctl_t;

	typedef struct packed {
		logic valid;
		logic full;
	} queue_stat_t;

endpackage

### hdl/pdvd_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdvd_in_if: byte channel of the postings decoder
// Carries one raw byte of a postings block and its start mark per beat.
// ----------------------------------------------------------------------------
interface pdvd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       list_start;

	modport source (output valid, output in_byte, output list_start, input ready);
	modport sink   (input valid, input in_byte, input list_start, output ready);
endinterface

### hdl/pdvd_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdvd_out_if: document id channel of the postings decoder
// Carries one decoded document id and its status flags per beat.
// ----------------------------------------------------------------------------
interface pdvd_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] doc_id;
	logic        is_last;
	logic        empty_list;
	logic        overflow;

	modport source (output valid, output doc_id, output is_last, output empty_list,
		output overflow, input ready);
	modport sink   (input valid, input doc_id, input is_last, input empty_list,
		input overflow, output ready);
endinterface

### hdl/pdvd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdvd_front: byte parser of the postings decoder
// Takes the count header, assembles each varint delta and pushes one job per
// result into the queue, with the last, empty and overflow marks resolved.
// ----------------------------------------------------------------------------
module pdvd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          in_byte,
	input  logic                list_start,
	output logic                push,
	output pdvd_pkg::job_t      job
);

	logic [2:0]  seen_q;
	logic [31:0] count_q;
	logic [63:0] acc_q;
	logic [3:0]  idx_q;
	logic        active_q;
	logic        first_q;

	logic [2:0]  seen_c, seen_n;
	logic [31:0] count_c, count_n;
	logic [63:0] acc_c, acc_n;
	logic [3:0]  idx_c, idx_n;
	logic        active_c, active_n;
	logic        first_c, first_n;
	logic [6:0]  shift7;
	logic [31:0] hdr_part;

	always_comb begin
		seen_c   = list_start ? 3'd0 : seen_q;
		count_c  = list_start ? 32'd0 : count_q;
		acc_c    = list_start ? 64'd0 : acc_q;
		idx_c    = list_start ? 4'd0 : idx_q;
		active_c = list_start | active_q;
		first_c  = list_start | first_q;

		seen_n   = seen_c;
		count_n  = count_c;
		acc_n    = acc_c;
		idx_n    = idx_c;
		active_n = active_c;
		first_n  = first_c;

		shift7   = {idx_c, 3'b000} - {3'b000, idx_c};
		hdr_part = {24'd0, in_byte} << {seen_c[1:0], 3'b000};

		push       = 1'b0;
		job.delta  = acc_c;
		job.first  = first_c;
		job.last   = 1'b1;
		job.empty  = 1'b0;
		job.ovf    = 1'b0;

		if (active_c) begin
			if (seen_c < 3'(pdvd_pkg::HEADER_LEN)) begin
				count_n = count_c | hdr_part;
				seen_n  = seen_c + 3'd1;
				if (seen_c == 3'(pdvd_pkg::HEADER_LEN - 1) && count_n == 32'd0) begin
					push      = 1'b1;
					job.empty = 1'b1;
					active_n  = 1'b0;
				end
			end else if (idx_c >= 4'(pdvd_pkg::MAX_VARINT_BYTES - 1)) begin
				if (in_byte > 8'd1) begin
					push     = 1'b1;
					job.ovf  = 1'b1;
					active_n = 1'b0;
					acc_n    = 64'd0;
					idx_n    = 4'd0;
				end else begin
					push      = 1'b1;
					job.delta = acc_c | {in_byte[0], 63'd0};
					job.last  = (count_c == 32'd1);
					count_n   = count_c - 32'd1;
					active_n  = (count_c != 32'd1);
					first_n   = 1'b0;
					acc_n     = 64'd0;
					idx_n     = 4'd0;
				end
			end else begin
				acc_n = acc_c | ({57'd0, in_byte[6:0]} << shift7[5:0]);
				if (in_byte[7]) begin
					idx_n = idx_c + 4'd1;
				end else begin
					push      = 1'b1;
					job.delta = acc_n;
					job.last  = (count_c == 32'd1);
					count_n   = count_c - 32'd1;
					active_n  = (count_c != 32'd1);
					first_n   = 1'b0;
					acc_n     = 64'd0;
					idx_n     = 4'd0;
				end
			end
		end
		push = push & accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q   <= 3'd0;
			count_q  <= 32'd0;
			acc_q    <= 64'd0;
			idx_q    <= 4'd0;
			active_q <= 1'b0;
			first_q  <= 1'b0;
		end else if (accept) begin
			seen_q   <= seen_n;
			count_q  <= count_n;
			acc_q    <= acc_n;
			idx_q    <= idx_n;
			active_q <= active_n;
			first_q  <= first_n;
		end
	end

endmodule

### hdl/pdvd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdvd_queue: job queue between parser and accumulator
// A short register queue that lets the parser and the accumulator stall
// independently; a push and a pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module pdvd_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pdvd_pkg::queue_ctl_t  ctl,
	input  pdvd_pkg::job_t        wr_job,
	output pdvd_pkg::job_t        rd_job,
	output pdvd_pkg::queue_stat_t stat
);

	pdvd_pkg::job_t entry_q [pdvd_pkg::QUEUE_DEPTH];

	logic [pdvd_pkg::QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [pdvd_pkg::QUEUE_CNT_W-1:0] cnt_q;

	assign stat.valid = (cnt_q != '0);
	assign stat.full  = (cnt_q == pdvd_pkg::QUEUE_CNT_W'(pdvd_pkg::QUEUE_DEPTH));
	assign rd_job     = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			entry_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (ctl.push) begin
				wr_ptr_q <= (wr_ptr_q == pdvd_pkg::QUEUE_PTR_W'(pdvd_pkg::QUEUE_DEPTH - 1))
					? '0 : wr_ptr_q + 1'b1;
			end
			if (ctl.pop) begin
				rd_ptr_q <= (rd_ptr_q == pdvd_pkg::QUEUE_PTR_W'(pdvd_pkg::QUEUE_DEPTH - 1))
					? '0 : rd_ptr_q + 1'b1;
			end
			case ({ctl.push, ctl.pop})
				2'b10:   cnt_q <= cnt_q + pdvd_pkg::QUEUE_CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - pdvd_pkg::QUEUE_CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### hdl/pdvd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdvd_back: id accumulator of the postings decoder
// Adds each delta to the running document id and holds the result in the
// output register until the sink takes it.
// ----------------------------------------------------------------------------
module pdvd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            job_valid,
	input  pdvd_pkg::job_t  job,
	output logic            pop,
	pdvd_out_if.source      ids
);

	logic [63:0] prev_q;
	logic [63:0] doc_id_q;
	logic        valid_q, last_q, empty_q, ovf_q;
	logic [63:0] sum;

	assign pop = job_valid && (!valid_q || ids.ready);
	assign sum = (job.first ? 64'd0 : prev_q) + job.delta;

	always_ff @(posedge clk) begin
		if (pop) begin
			last_q  <= job.last;
			empty_q <= job.empty;
			ovf_q   <= job.ovf;
			if (job.empty || job.ovf) begin
				doc_id_q <= 64'd0;
			end else begin
				doc_id_q <= sum;
				prev_q   <= sum;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (ids.ready) begin
			valid_q <= 1'b0;
		end
	end

	assign ids.valid      = valid_q;
	assign ids.doc_id     = doc_id_q;
	assign ids.is_last    = last_q;
	assign ids.empty_list = empty_q;
	assign ids.overflow   = ovf_q;

endmodule

### hdl/postings_delta_varint_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// postings_delta_varint_decoder: delta LEB128 postings list decoder
// Turns the bytes of a postings block into document ids.
//
//   channel  dir  beat contents
//   bytes    in   in_byte, list_start
//   ids      out  doc_id, is_last, empty_list, overflow
//
// One byte is taken per cycle while the two-entry job queue has room.
// A result passes through the job queue and then the 64-bit add into the
// output register before it appears on ids.
// Reset clears the parser, the queue and the output valid; no list is active.
// A stalled ids sink fills the queue, and bytes then wait until it drains.
// ----------------------------------------------------------------------------
module postings_delta_varint_decoder (
	input  logic      clk,
	input  logic      arst_n,
	pdvd_in_if.sink   bytes,
	pdvd_out_if.source ids
);

	pdvd_pkg::job_t        wr_job, rd_job;
	pdvd_pkg::queue_ctl_t  qctl;
	pdvd_pkg::queue_stat_t qstat;
	logic                  accept;
	logic                  push, pop;

	assign bytes.ready = !qstat.full;
	assign accept      = bytes.valid && !qstat.full;
	assign qctl.push   = push;
	assign qctl.pop    = pop;

	pdvd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.in_byte    (bytes.in_byte),
		.list_start (bytes.list_start),
		.push       (push),
		.job        (wr_job)
	);

	pdvd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (qctl),
		.wr_job (wr_job),
		.rd_job (rd_job),
		.stat   (qstat)
	);

	pdvd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (qstat.valid),
		.job       (rd_job),
		.pop       (pop),
		.ids       (ids)
	);

endmodule

### hdl/pdvd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdvd_checker: port assertions of the postings decoder
// Checks output beats against their flag meaning, stall hold and reset.
// ----------------------------------------------------------------------------
module pdvd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] doc_id,
	input logic        is_last,
	input logic        empty_list,
	input logic        overflow
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(doc_id) && $stable(is_last))
		else $error("output beat changed while stalled");

	a_empty_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && empty_list |-> doc_id == 64'd0 && is_last && !overflow)
		else $error("empty list beat is malformed");

	a_ovf_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> doc_id == 64'd0 && is_last && !empty_list)
		else $error("overflow beat is malformed");

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("output valid during reset");

endmodule

bind postings_delta_varint_decoder pdvd_checker u_pdvd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (ids.valid),
	.out_ready  (ids.ready),
	.doc_id     (ids.doc_id),
	.is_last    (ids.is_last),
	.empty_list (ids.empty_list),
	.overflow   (ids.overflow)
);
